FILE: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table: response
// status codes, controller states and the command and status groups that
// pass between controller and datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int SLOT_W    = 7;
   localparam int PROBE_W   = 8;
   localparam int MOD_CSR_W = 8;

   localparam logic [MOD_CSR_W-1:0] MOD_RESET = 8'd128;
   localparam logic [PROBE_W-1:0]   PROBE_MAX = 8'hFF;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_DUP       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_FETCH,
      S_PROBE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       clear_step;
      logic       accept;
      logic       hash_step;
      logic       fetch;
      logic       probe_next;
      logic       store;
      logic       set_result;
      logic       res_use_pos;
      status_type res_status;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic key_zero;
      logic div_last;
      logic hit;
      logic empty;
      logic probe_last;
      logic lookup;
   } stat_type;

endpackage

FILE: rtl/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_if
// Request and response channels of the hash table, each a valid/ready
// handshake with its payload.
// ----------------------------------------------------------------------------
interface lpht_req_if #(
   parameter int KEY_BITS = 16
) ();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [KEY_BITS-1:0] key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface lpht_rsp_if
   import lpht_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  slot;
   logic [PROBE_W-1:0] probes;
   logic [1:0]         status;

   modport source (output valid, output slot, output probes, output status, input ready);
   modport sink   (input valid, input slot, input probes, input status, output ready);
endinterface

FILE: rtl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller of the hash table: clearing pass after reset, request accept,
// remainder steps, probe walk decisions and the response handshake.
// ----------------------------------------------------------------------------
module lpht_ctrl
   import lpht_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.res_status = ST_OK;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.key_zero) begin
                  cmd.set_result = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_FINISH;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_PROBE;
         end
         S_PROBE: begin
            priority if (stat.hit) begin
               cmd.set_result  = 1'b1;
               cmd.res_use_pos = stat.lookup;
               cmd.res_status  = stat.lookup ? ST_OK : ST_DUP;
               state_in        = S_FINISH;
            end else if (stat.empty) begin
               cmd.set_result  = 1'b1;
               cmd.res_use_pos = !stat.lookup;
               cmd.store       = !stat.lookup;
               cmd.res_status  = stat.lookup ? ST_NOT_FOUND : ST_OK;
               state_in        = S_FINISH;
            end else if (stat.probe_last) begin
               cmd.set_result = 1'b1;
               cmd.res_status = stat.lookup ? ST_NOT_FOUND : ST_FULL;
               state_in       = S_FINISH;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/lpht_dpath.sv
// ----------------------------------------------------------------------------
// lpht_dpath
// Datapath of the hash table: modulus register, bit-serial remainder unit,
// key store with registered read, probe position and count, result and
// response registers.
// ----------------------------------------------------------------------------
module lpht_dpath
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = 128,
   parameter int KEY_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic                 in_req_type,
   input  logic [KEY_BITS-1:0]  in_key,
   input  logic                 csr_write_enable,
   input  logic [MOD_CSR_W-1:0] csr_write_data,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [PROBE_W-1:0]   rsp_probes,
   output logic [1:0]           rsp_status
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CNT_W = $clog2(TABLE_SIZE + 1);
   localparam int MOD_W = CNT_W;
   localparam int BIT_W = $clog2(KEY_BITS);

   logic [KEY_BITS-1:0] mem [TABLE_SIZE];

   logic [MOD_CSR_W-1:0] csr_modulus_ff, csr_modulus_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [KEY_BITS-1:0]  shift_ff, shift_in;
   logic                 lookup_ff, lookup_in;
   logic [MOD_W-1:0]     m_ff, m_in;
   logic [MOD_W-1:0]     rem_ff, rem_in;
   logic [BIT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [KEY_BITS-1:0]  rd_data_ff;
   logic [IDX_W-1:0]     res_slot_ff, res_slot_in;
   logic [CNT_W-1:0]     res_probes_ff, res_probes_in;
   status_type           res_status_ff, res_status_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [PROBE_W-1:0]   rsp_probes_ff, rsp_probes_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic [MOD_W-1:0]         m_eff;
   logic [MOD_W:0]           trial;
   logic [MOD_W-1:0]         rem_step;
   logic [IDX_W-1:0]         pos_next;
   logic [IDX_W-1:0]         rd_addr;
   logic                     mem_we;
   logic [KEY_BITS-1:0]      mem_wdata;
   logic [IDX_W+SLOT_W-1:0]  slot_wide;
   logic [CNT_W+PROBE_W-1:0] probes_wide;

   // modulus of zero or beyond the table acts as the table size
   always_comb begin
      if (csr_modulus_ff == '0 || int'(csr_modulus_ff) > TABLE_SIZE) begin
         m_eff = MOD_W'(TABLE_SIZE);
      end else begin
         m_eff = MOD_W'(csr_modulus_ff);
      end
   end

   // one quotient bit per cycle
   assign trial    = {rem_ff, shift_ff[KEY_BITS-1]};
   assign rem_step = (trial >= {1'b0, m_ff}) ? MOD_W'(trial - {1'b0, m_ff})
                                             : trial[MOD_W-1:0];

   assign pos_next  = (pos_ff == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos_ff + 1'b1;
   assign rd_addr   = cmd.fetch ? rem_ff[IDX_W-1:0] : pos_next;
   assign mem_we    = cmd.clear_step || cmd.store;
   assign mem_wdata = cmd.store ? key_ff : '0;

   assign slot_wide   = {{SLOT_W{1'b0}}, res_slot_ff};
   assign probes_wide = {{PROBE_W{1'b0}}, res_probes_ff};

   always_comb begin
      csr_modulus_in = csr_write_enable ? csr_write_data : csr_modulus_ff;
      key_in         = key_ff;
      shift_in       = shift_ff;
      lookup_in      = lookup_ff;
      m_in           = m_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      res_slot_in    = res_slot_ff;
      res_probes_in  = res_probes_ff;
      res_status_in  = res_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_probes_in  = rsp_probes_ff;
      rsp_status_in  = rsp_status_ff;

      if (cmd.accept) begin
         key_in     = in_key;
         shift_in   = in_key;
         lookup_in  = in_req_type;
         m_in       = m_eff;
         rem_in     = '0;
         div_cnt_in = '0;
      end
      if (cmd.hash_step) begin
         rem_in     = rem_step;
         shift_in   = {shift_ff[KEY_BITS-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (cmd.fetch) begin
         pos_in   = rem_ff[IDX_W-1:0];
         count_in = CNT_W'(1);
      end
      if (cmd.probe_next || cmd.clear_step) begin
         pos_in   = pos_next;
         count_in = count_ff + 1'b1;
      end
      if (cmd.set_result) begin
         res_slot_in   = cmd.res_use_pos ? pos_ff : '0;
         res_probes_in = cmd.accept ? '0 : count_ff;
         res_status_in = cmd.res_status;
      end
      if (cmd.load_rsp) begin
         rsp_slot_in   = slot_wide[SLOT_W-1:0];
         rsp_probes_in = (probes_wide > (CNT_W+PROBE_W)'(PROBE_MAX)) ? PROBE_MAX
                                                                      : probes_wide[PROBE_W-1:0];
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_modulus_ff <= MOD_RESET;
         pos_ff         <= '0;
      end else begin
         csr_modulus_ff <= csr_modulus_in;
         pos_ff         <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      shift_ff      <= shift_in;
      lookup_ff     <= lookup_in;
      m_ff          <= m_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      count_ff      <= count_in;
      res_slot_ff   <= res_slot_in;
      res_probes_ff <= res_probes_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_probes_ff <= rsp_probes_in;
      rsp_status_ff <= rsp_status_in;
   end

   // key store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pos_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign stat.clear_last = (pos_ff == IDX_W'(TABLE_SIZE - 1));
   assign stat.key_zero   = (in_key == '0);
   assign stat.div_last   = (div_cnt_ff == BIT_W'(KEY_BITS - 1));
   assign stat.hit        = (rd_data_ff == key_ff);
   assign stat.empty      = (rd_data_ff == '0);
   assign stat.probe_last = (count_ff == CNT_W'(TABLE_SIZE));
   assign stat.lookup     = lookup_ff;

   assign rsp_slot   = rsp_slot_ff;
   assign rsp_probes = rsp_probes_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table of nonzero keys with division hashing and
// linear probing.
//
// A request carries req_type (insert or lookup) and a key. Each request gives
// one response with the slot, the number of slots compared and a status.
// The home slot is key mod modulus, set through csr_write_enable and
// csr_write_data while no request is in flight.
// The remainder is formed one key bit per cycle, then the probe walk
// compares one slot per cycle against the store's registered read. A zero
// key is answered as not found without a probe walk. One request is worked
// on at a time: a new request is not taken before the last one has reached
// its result. After reset a clearing pass empties the store; no request is
// taken during it. The response is held in an output register: a new
// request is taken while it waits, and the block waits at the end of that
// next request until the receiver takes the held response.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = 128,
   parameter int KEY_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   lpht_req_if.sink             req_ch,
   lpht_rsp_if.source           rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [MOD_CSR_W-1:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpht_dpath #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_req_type      (req_ch.req_type),
      .in_key           (req_ch.key),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_slot         (rsp_ch.slot),
      .rsp_probes       (rsp_ch.probes),
      .rsp_status       (rsp_ch.status)
   );

endmodule

FILE: rtl/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_props
// Port-level checks of the hash table: response hold, clearing pass after
// reset and consistency of slot, probe count and status.
// ----------------------------------------------------------------------------
module lpht_props
   import lpht_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SLOT_W-1:0]  rsp_slot,
   input logic [PROBE_W-1:0] rsp_probes,
   input logic [1:0]         rsp_status
);

   // stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // request side not ready right after reset, as the clearing pass begins
   a_clear_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // every status other than not found comes from a compare
   a_probe_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_NOT_FOUND |-> rsp_probes != '0)
      else $error("response without any probe");

   // failures report slot zero
   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_DUP ||
                    rsp_status == ST_NOT_FOUND) |-> rsp_slot == '0)
      else $error("failure response with nonzero slot");

endmodule

bind linear_probe_hash_table lpht_props u_lpht_props (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_slot   (rsp_ch.slot),
   .rsp_probes (rsp_ch.probes),
   .rsp_status (rsp_ch.status)
);

FILE: sim/lpht_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpht_tb_pkg
// Request type codes shared by the stimulus and the checker of the hash
// table testbench.
// ----------------------------------------------------------------------------
package lpht_tb_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

endpackage

FILE: sim/lpht_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the request, response and register ports of the hash table. It
// keeps its own copy of the slot store and the modulus, works out the
// response to every accepted request and compares each accepted response,
// field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module lpht_checker
   import lpht_pkg::*;
   import lpht_tb_pkg::*;
#(
   parameter int TABLE_SIZE = 128,
   parameter int KEY_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_type,
   input  logic [KEY_BITS-1:0]  req_key,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [SLOT_W-1:0]    rsp_slot,
   input  logic [PROBE_W-1:0]   rsp_probes,
   input  logic [1:0]           rsp_status,
   input  logic                 csr_write_enable,
   input  logic [MOD_CSR_W-1:0] csr_write_data,
   output int                   error_count,
   output int                   waiting,
   output int                   request_count,
   output int                   ok_count,
   output int                   miss_count,
   output int                   full_count,
   output int                   dup_count,
   output int                   occupied
);

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [PROBE_W-1:0] probes;
      status_type         status;
   } probe_outcome_type;

   logic [KEY_BITS-1:0]  slot_keys [TABLE_SIZE];
   logic [MOD_CSR_W-1:0] modulus_q;
   probe_outcome_type    owed_responses [$];

   // walks the probe path and applies an insert to the local store
   function automatic probe_outcome_type walk_table(input logic is_lookup,
                                                    input logic [KEY_BITS-1:0] key);
      probe_outcome_type res;
      int                m;
      int                pos;
      res.slot   = '0;
      res.probes = '0;
      res.status = ST_NOT_FOUND;
      if (key == '0)
         return res;
      m = int'(modulus_q);
      if (m == 0 || m > TABLE_SIZE)
         m = TABLE_SIZE;
      pos = int'(key) % m;
      for (int n = 1; n <= TABLE_SIZE; n++) begin
         if (slot_keys[pos] == key) begin
            res.probes = (n > 255) ? PROBE_MAX : PROBE_W'(n);
            res.status = is_lookup ? ST_OK : ST_DUP;
            res.slot   = is_lookup ? SLOT_W'(pos) : '0;
            return res;
         end
         if (slot_keys[pos] == '0) begin
            res.probes = (n > 255) ? PROBE_MAX : PROBE_W'(n);
            if (is_lookup) begin
               res.status = ST_NOT_FOUND;
            end else begin
               slot_keys[pos] = key;
               if (occupied < 255)
                  occupied++;
               res.status = ST_OK;
               res.slot   = SLOT_W'(pos);
            end
            return res;
         end
         pos = (pos + 1) % TABLE_SIZE;
      end
      res.probes = (TABLE_SIZE > 255) ? PROBE_MAX : PROBE_W'(TABLE_SIZE);
      res.status = is_lookup ? ST_NOT_FOUND : ST_FULL;
      return res;
   endfunction

   always @(posedge clock) begin
      probe_outcome_type exp_res;
      if (reset) begin
         foreach (slot_keys[i])
            slot_keys[i] = '0;
         modulus_q = MOD_RESET;
         owed_responses.delete();
         occupied = 0;
      end else begin
         if (csr_write_enable)
            modulus_q = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: response with none owed: slot %0d probes %0d status %0d",
                           $time, rsp_slot, rsp_probes, rsp_status);
            end else begin
               exp_res = owed_responses.pop_front();
               if (rsp_slot !== exp_res.slot || rsp_probes !== exp_res.probes ||
                   rsp_status !== exp_res.status) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t: mismatch: expected slot %0d probes %0d status %0d",
                              $time, exp_res.slot, exp_res.probes, exp_res.status);
                     $display("%0t: mismatch: actual   slot %0d probes %0d status %0d",
                              $time, rsp_slot, rsp_probes, rsp_status);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            exp_res = walk_table(req_type == OP_LOOKUP, req_key);
            owed_responses.push_back(exp_res);
            request_count++;
            unique case (exp_res.status)
               ST_OK:        ok_count++;
               ST_NOT_FOUND: miss_count++;
               ST_FULL:      full_count++;
               ST_DUP:       dup_count++;
            endcase
         end
      end
      waiting = owed_responses.size();
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the hash table with a short directed sequence (zero key, extreme
// keys, wrap at the table end, duplicate insert) and then random insert and
// lookup phases under several modulus settings, in and out of range, the
// last two weighted toward inserts. Both channels stall at random and the
// response side holds off once for a long stretch. A separate checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import lpht_pkg::*;
   import lpht_tb_pkg::*;

   localparam int TABLE_SIZE  = 128;
   localparam int KEY_BITS    = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_ITEMS = 48;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [MOD_CSR_W-1:0] csr_write_data;

   int error_count;
   int waiting;
   int request_count;
   int ok_count;
   int miss_count;
   int full_count;
   int dup_count;
   int occupied;

   bit idle_on;
   bit hold_wanted;
   bit hold_done;
   int stall_cycles;
   int settings_used;

   logic [KEY_BITS-1:0]  key_pool [$];
   logic [MOD_CSR_W-1:0] moduli [8] = '{8'd13, 8'd1, 8'd128, 8'd0, 8'd64, 8'd200, 8'd255, 8'd97};

   lpht_req_if #(.KEY_BITS(KEY_BITS)) req_ch ();
   lpht_rsp_if                        rsp_ch ();

   linear_probe_hash_table #(
      .TABLE_SIZE(TABLE_SIZE),
      .KEY_BITS  (KEY_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   lpht_checker #(
      .TABLE_SIZE(TABLE_SIZE),
      .KEY_BITS  (KEY_BITS)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_type        (req_ch.req_type),
      .req_key         (req_ch.key),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_slot        (rsp_ch.slot),
      .rsp_probes      (rsp_ch.probes),
      .rsp_status      (rsp_ch.status),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .error_count     (error_count),
      .waiting         (waiting),
      .request_count   (request_count),
      .ok_count        (ok_count),
      .miss_count      (miss_count),
      .full_count      (full_count),
      .dup_count       (dup_count),
      .occupied        (occupied)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // no request or response accepted for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // response side: random stalls plus one long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_done) begin
            rsp_ch.ready = 1'b0;
            hold_done    = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (idle_on && $urandom_range(0, 6) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
      end
   end

   task automatic send_request(input logic op, input logic [KEY_BITS-1:0] k);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.req_type = op;
      req_ch.key      = k;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
      if (op == OP_INSERT && k != '0)
         key_pool.push_back(k);
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (waiting != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_modulus(input logic [MOD_CSR_W-1:0] value);
      csr_write_data   = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      settings_used++;
   endtask

   // mix of stored keys, home slot collisions, extremes and plain random keys
   function automatic logic [KEY_BITS-1:0] pick_key(input logic [MOD_CSR_W-1:0] m);
      int sel;
      int mm;
      sel = $urandom_range(0, 99);
      mm  = (m == 0 || m > TABLE_SIZE) ? TABLE_SIZE : int'(m);
      if (sel < 3)
         return '0;
      if (sel < 6)
         return '1;
      if (sel < 40 && key_pool.size() > 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (sel < 70)
         return KEY_BITS'(mm * $urandom_range(1, 65535 / mm) + $urandom_range(0, 2));
      return KEY_BITS'($urandom_range(1, 65535));
   endfunction

   task automatic run_phase(input logic [MOD_CSR_W-1:0] m, input int insert_pct);
      logic op;
      write_modulus(m);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
         send_request(op, pick_key(m));
      end
      wait_drained();
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = OP_INSERT;
      req_ch.key       = '0;
      idle_on          = 1'b1;
      hold_wanted      = 1'b0;
      settings_used    = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // directed: extremes, wrap at the table end, duplicate, zero key
      write_modulus(8'd128);
      send_request(OP_INSERT, 16'h0001);
      send_request(OP_LOOKUP, 16'h0001);
      send_request(OP_INSERT, 16'h0001);
      send_request(OP_LOOKUP, 16'h0002);
      send_request(OP_LOOKUP, 16'hFFFF);
      send_request(OP_INSERT, 16'hFFFF);
      send_request(OP_INSERT, 16'h7FFF);
      send_request(OP_LOOKUP, 16'h7FFF);
      send_request(OP_INSERT, 16'h807F);
      send_request(OP_LOOKUP, 16'h807F);
      send_request(OP_INSERT, 16'h0000);
      send_request(OP_LOOKUP, 16'h0000);
      send_request(OP_INSERT, 16'h8000);
      send_request(OP_LOOKUP, 16'h8000);
      send_request(OP_INSERT, 16'hAAAA);
      send_request(OP_LOOKUP, 16'h5555);
      send_request(OP_LOOKUP, 16'hAAAA);
      send_request(OP_LOOKUP, 16'h017F);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         idle_on     = (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
         hold_wanted = (p == 1);
         run_phase(moduli[p], (p >= 6) ? 85 : 55);
      end

      repeat (40) @(negedge clock);
      $display("covered %0d requests over %0d modulus settings",
               request_count, settings_used);
      $display("outcomes: %0d ok, %0d not found, %0d full, %0d duplicate",
               ok_count, miss_count, full_count, dup_count);
      $display("table ended with %0d of %0d slots in use; one response hold-off of %0d cycles",
               occupied, TABLE_SIZE, HOLD_CYCLES);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
